// ----- hdl/segaabb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segaabb_pkg
// Shared constants for the segment versus axis-aligned box entry test.
// ----------------------------------------------------------------------------
package segaabb_pkg;

    // entry axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // back end register stages and result queue depth
    localparam int BACK_STAGES = 3;
    localparam int OUT_DEPTH   = 8;

endpackage
`default_nettype wire

// ----- hdl/segaabb_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segaabb_fifo
// Small synchronous queue with occupancy count.
// ----------------------------------------------------------------------------
module segaabb_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    input  wire logic          i_pop,
    output logic      [DW-1:0] o_data,
    output logic               o_empty,
    output logic      [CW-1:0] o_count
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          push_ok, pop_ok;

    assign push_ok = i_push && (r_cnt != CW'(DEPTH));
    assign pop_ok  = i_pop && (r_cnt != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop_ok) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + CW'(push_ok) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule
`default_nettype wire

// ----- hdl/segaabb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segaabb_front
// Classify each axis and compute candidate entry times with a pipelined
// restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module segaabb_front #(
    parameter int COORD_BITS     = 32,
    parameter int TIME_FRAC_BITS = 16,
    parameter int MID_DEPTH      = 20,
    localparam int W   = COORD_BITS,
    localparam int F   = TIME_FRAC_BITS,
    localparam int QCW = $clog2(MID_DEPTH + 1),
    localparam int MW  = 4 + 3 * (TIME_FRAC_BITS + 1) + 12 * COORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic signed [W-1:0]  i_start_x,
    input  wire logic signed [W-1:0]  i_start_y,
    input  wire logic signed [W-1:0]  i_start_z,
    input  wire logic signed [W-1:0]  i_dir_x,
    input  wire logic signed [W-1:0]  i_dir_y,
    input  wire logic signed [W-1:0]  i_dir_z,
    input  wire logic signed [W-1:0]  i_box_min_x,
    input  wire logic signed [W-1:0]  i_box_max_x,
    input  wire logic signed [W-1:0]  i_box_min_y,
    input  wire logic signed [W-1:0]  i_box_max_y,
    input  wire logic signed [W-1:0]  i_box_min_z,
    input  wire logic signed [W-1:0]  i_box_max_z,
    input  wire logic [QCW-1:0]       i_q_count,
    output logic                      o_valid,
    output logic [MW-1:0]             o_data
);

    import segaabb_pkg::*;

    localparam int FCW = $clog2(F + 2);
    localparam int SW  = QCW + FCW;

    typedef struct packed {
        logic [2:0][W-1:0] r;
        logic [2:0][W-1:0] den;
        logic [2:0][F-1:0] q;
        logic [2:0]        one;
        logic [2:0]        cand;
        logic              miss;
        logic [2:0][W-1:0] s, d, lo, hi;
    } t_stg;

    typedef struct packed {
        logic              miss;
        logic [2:0]        cand;
        logic [2:0][F:0]   t;
        logic [2:0][W-1:0] s, d, lo, hi;
    } t_mid;

    function automatic t_stg f_step(input t_stg x);
        t_stg       y;
        logic [W:0] r2;
        logic       ge;
        y = x;
        for (int a = 0; a < 3; a++) begin
            r2 = {x.r[a], 1'b0};
            ge = (r2 >= {1'b0, x.den[a]});
            y.r[a] = ge ? W'(r2 - {1'b0, x.den[a]}) : r2[W-1:0];
            y.q[a] = {x.q[a][F-2:0], ge};
        end
        return y;
    endfunction

    logic [2:0][W-1:0]  s, d, lo, hi;
    logic signed [W:0]  dlo [3];
    logic signed [W:0]  dhi [3];
    logic signed [W:0]  ndhi [3];
    logic signed [W:0]  dx [3];
    logic signed [W:0]  ad [3];
    logic [2:0]         below, above, unreach;
    t_stg               n_st0;
    t_stg               r_st [F+1];
    t_stg               n_st [F+1];
    logic [F:0]         r_vl;
    logic [FCW-1:0]     r_fly, n_fly;
    logic               acc;
    t_mid               mid;

    assign s  = {i_start_z, i_start_y, i_start_x};
    assign d  = {i_dir_z, i_dir_y, i_dir_x};
    assign lo = {i_box_min_z, i_box_min_y, i_box_min_x};
    assign hi = {i_box_max_z, i_box_max_y, i_box_max_x};

    always_comb begin
        n_st0 = '0;
        n_st0.s  = s;
        n_st0.d  = d;
        n_st0.lo = lo;
        n_st0.hi = hi;
        for (int a = 0; a < 3; a++) begin
            dlo[a]  = $signed({lo[a][W-1], lo[a]}) - $signed({s[a][W-1], s[a]});
            dhi[a]  = $signed({hi[a][W-1], hi[a]}) - $signed({s[a][W-1], s[a]});
            ndhi[a] = -dhi[a];
            dx[a]   = $signed({d[a][W-1], d[a]});
            ad[a]   = (dx[a] < 0) ? -dx[a] : dx[a];
            below[a] = $signed(s[a]) < $signed(lo[a]);
            above[a] = !below[a] && ($signed(s[a]) > $signed(hi[a]));
            if (below[a]) begin
                unreach[a] = dlo[a] > dx[a];
            end else if (above[a]) begin
                unreach[a] = dhi[a] < dx[a];
            end else begin
                unreach[a] = 1'b0;
            end
            n_st0.r[a]    = below[a] ? dlo[a][W-1:0] : ndhi[a][W-1:0];
            n_st0.den[a]  = ad[a][W-1:0];
            n_st0.one[a]  = n_st0.r[a] >= n_st0.den[a];
            n_st0.cand[a] = below[a] | above[a];
        end
        n_st0.miss = (|unreach) || !(|n_st0.cand);
    end

    always_comb begin
        n_st[0] = n_st0;
        for (int k = 1; k <= F; k++) begin
            n_st[k] = f_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= F; k++) begin
            r_st[k] <= n_st[k];
        end
    end

    assign acc    = i_push && !o_full;
    assign o_full = (SW'(r_fly) + SW'(i_q_count)) >= SW'(MID_DEPTH);
    assign n_fly  = r_fly + FCW'(acc) - FCW'(r_vl[F]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl  <= '0;
            r_fly <= '0;
        end else begin
            r_vl  <= {r_vl[F-1:0], acc};
            r_fly <= n_fly;
        end
    end

    always_comb begin
        mid.miss = r_st[F].miss;
        mid.cand = r_st[F].cand;
        mid.s    = r_st[F].s;
        mid.d    = r_st[F].d;
        mid.lo   = r_st[F].lo;
        mid.hi   = r_st[F].hi;
        for (int a = 0; a < 3; a++) begin
            mid.t[a] = r_st[F].one[a] ? {1'b1, {F{1'b0}}} : {1'b0, r_st[F].q[a]};
        end
    end

    assign o_valid = r_vl[F];
    assign o_data  = mid;

endmodule
`default_nettype wire

// ----- hdl/segaabb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segaabb_back
// Pick the entry plane, form the entry point, check bounds and saturate.
// ----------------------------------------------------------------------------
module segaabb_back #(
    parameter int COORD_BITS     = 32,
    parameter int TIME_FRAC_BITS = 16,
    localparam int W   = COORD_BITS,
    localparam int F   = TIME_FRAC_BITS,
    localparam int MW  = 4 + 3 * (TIME_FRAC_BITS + 1) + 12 * COORD_BITS,
    localparam int RW  = 4 + 3 * COORD_BITS + TIME_FRAC_BITS,
    localparam int OCW = $clog2(segaabb_pkg::OUT_DEPTH + 1)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    output logic                o_pop,
    input  wire logic [MW-1:0]  i_data,
    input  wire logic [OCW-1:0] i_out_count,
    output logic                o_valid,
    output logic [RW-1:0]       o_data
);

    import segaabb_pkg::*;

    localparam int BCW = $clog2(BACK_STAGES + 1);
    localparam int SW  = OCW + BCW;

    typedef struct packed {
        logic              miss;
        logic [2:0]        cand;
        logic [2:0][F:0]   t;
        logic [2:0][W-1:0] s, d, lo, hi;
    } t_mid;

    typedef struct packed {
        logic              miss;
        logic [1:0]        best;
        logic [F:0]        tb;
        logic [2:0][W-1:0] s, d, lo, hi;
    } t_b1;

    typedef struct packed {
        logic                miss;
        logic [1:0]          best;
        logic [F:0]          tb;
        logic [2:0]          neg;
        logic [2:0][W+F:0]   prod;
        logic [2:0][W-1:0]   s, lo, hi;
    } t_b2;

    typedef struct packed {
        logic              hit;
        logic [2:0][W-1:0] p;
        logic [1:0]        axis;
        logic [F:0]        t;
    } t_res;

    t_mid               mi;
    t_b1                r_b1, n_b1;
    t_b2                r_b2, n_b2;
    t_res               r_res, n_res;
    logic [2:0]         r_v;
    logic [BCW-1:0]     r_fly;
    logic [1:0]         b01;
    logic               take1, take2;
    logic signed [W:0]  dx [3];
    logic signed [W:0]  ad [3];
    logic [W:0]         off [3];
    logic signed [W+1:0] p [3];
    logic [2:0]         oob;

    assign mi    = i_data;
    assign o_pop = !i_empty && ((SW'(r_fly) + SW'(i_out_count)) < SW'(OUT_DEPTH));

    // ties keep the lower axis
    always_comb begin
        take1 = mi.cand[1] && (!mi.cand[0] || (mi.t[1] > mi.t[0]));
        b01   = take1 ? AXIS_Y : AXIS_X;
        take2 = mi.cand[2] && (!mi.cand[b01] || (mi.t[2] > mi.t[b01]));
        n_b1.miss = mi.miss;
        n_b1.best = take2 ? AXIS_Z : b01;
        n_b1.tb   = mi.t[n_b1.best];
        n_b1.s    = mi.s;
        n_b1.d    = mi.d;
        n_b1.lo   = mi.lo;
        n_b1.hi   = mi.hi;
    end

    always_comb begin
        n_b2.miss = r_b1.miss;
        n_b2.best = r_b1.best;
        n_b2.tb   = r_b1.tb;
        n_b2.s    = r_b1.s;
        n_b2.lo   = r_b1.lo;
        n_b2.hi   = r_b1.hi;
        for (int a = 0; a < 3; a++) begin
            dx[a] = $signed({r_b1.d[a][W-1], r_b1.d[a]});
            ad[a] = (dx[a] < 0) ? -dx[a] : dx[a];
            n_b2.neg[a]  = r_b1.d[a][W-1];
            n_b2.prod[a] = (W+F+1)'(ad[a][W-1:0]) * (W+F+1)'(r_b1.tb);
        end
    end

    always_comb begin
        n_res = '0;
        for (int a = 0; a < 3; a++) begin
            off[a] = r_b2.prod[a][W+F:F];
            p[a] = r_b2.neg[a]
                 ? $signed({{2{r_b2.s[a][W-1]}}, r_b2.s[a]}) - $signed({1'b0, off[a]})
                 : $signed({{2{r_b2.s[a][W-1]}}, r_b2.s[a]}) + $signed({1'b0, off[a]});
            oob[a] = (r_b2.best != 2'(a)) &&
                     ((p[a] < $signed({{2{r_b2.lo[a][W-1]}}, r_b2.lo[a]})) ||
                      (p[a] > $signed({{2{r_b2.hi[a][W-1]}}, r_b2.hi[a]})));
        end
        n_res.hit = !r_b2.miss && !(|oob);
        if (n_res.hit) begin
            for (int a = 0; a < 3; a++) begin
                if (p[a] > $signed({3'b000, {(W-1){1'b1}}})) begin
                    n_res.p[a] = {1'b0, {(W-1){1'b1}}};
                end else if (p[a] < $signed({3'b111, {(W-1){1'b0}}})) begin
                    n_res.p[a] = {1'b1, {(W-1){1'b0}}};
                end else begin
                    n_res.p[a] = p[a][W-1:0];
                end
            end
            n_res.axis = r_b2.best;
            n_res.t    = r_b2.tb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1  <= n_b1;
        r_b2  <= n_b2;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_fly <= '0;
        end else begin
            r_v   <= {r_v[1:0], o_pop};
            r_fly <= r_fly + BCW'(o_pop) - BCW'(r_v[2]);
        end
    end

    assign o_valid = r_v[2];
    assign o_data  = r_res;

endmodule
`default_nettype wire

// ----- hdl/segment_aabb_intersect_top.sv -----
`default_nettype none
// From accepted transaction to result: classify at the accepting edge, the divider
// stages (one per quotient bit), the mid queue, the back end registers and the
// result queue. Throughput: one transaction per cycle while full is low, set by the
// fully pipelined divider and back end. Reset (synchronous, active low) empties
// both queues and the pipelines; no clearing pass.
// ----------------------------------------------------------------------------
// segment_aabb_intersect_top
// Segment versus axis-aligned box entry test in fixed point.
// ----------------------------------------------------------------------------
module segment_aabb_intersect_top #(
    parameter int COORD_BITS     = 32,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [COORD_BITS-1:0]  i_start_x,
    input  wire logic signed [COORD_BITS-1:0]  i_start_y,
    input  wire logic signed [COORD_BITS-1:0]  i_start_z,
    input  wire logic signed [COORD_BITS-1:0]  i_dir_x,
    input  wire logic signed [COORD_BITS-1:0]  i_dir_y,
    input  wire logic signed [COORD_BITS-1:0]  i_dir_z,
    input  wire logic signed [COORD_BITS-1:0]  i_box_min_x,
    input  wire logic signed [COORD_BITS-1:0]  i_box_max_x,
    input  wire logic signed [COORD_BITS-1:0]  i_box_min_y,
    input  wire logic signed [COORD_BITS-1:0]  i_box_max_y,
    input  wire logic signed [COORD_BITS-1:0]  i_box_min_z,
    input  wire logic signed [COORD_BITS-1:0]  i_box_max_z,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               o_hit,
    output logic signed [COORD_BITS-1:0]       o_hit_x,
    output logic signed [COORD_BITS-1:0]       o_hit_y,
    output logic signed [COORD_BITS-1:0]       o_hit_z,
    output logic [1:0]                         o_entry_axis,
    output logic [TIME_FRAC_BITS:0]            o_entry_time
);

    import segaabb_pkg::*;

    localparam int W         = COORD_BITS;
    localparam int F         = TIME_FRAC_BITS;
    localparam int MID_DEPTH = F + 4;
    localparam int MW        = 4 + 3 * (F + 1) + 12 * W;
    localparam int RW        = 4 + 3 * W + F;
    localparam int QCW       = $clog2(MID_DEPTH + 1);
    localparam int OCW       = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic              hit;
        logic [2:0][W-1:0] p;
        logic [1:0]        axis;
        logic [F:0]        t;
    } t_res;

    logic           f_valid;
    logic [MW-1:0]  f_data;
    logic [MW-1:0]  q_data;
    logic           q_empty;
    logic [QCW-1:0] q_count;
    logic           b_pop;
    logic           b_valid;
    logic [RW-1:0]  b_data;
    logic [OCW-1:0] o_count;
    t_res           res;

    segaabb_front #(
        .COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS), .MID_DEPTH(MID_DEPTH)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_start_x(i_start_x), .i_start_y(i_start_y), .i_start_z(i_start_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_box_min_x(i_box_min_x), .i_box_max_x(i_box_max_x),
        .i_box_min_y(i_box_min_y), .i_box_max_y(i_box_max_y),
        .i_box_min_z(i_box_min_z), .i_box_max_z(i_box_max_z),
        .i_q_count(q_count), .o_valid(f_valid), .o_data(f_data)
    );

    segaabb_fifo #(.DW(MW), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_valid), .i_data(f_data),
        .i_pop(b_pop), .o_data(q_data), .o_empty(q_empty), .o_count(q_count)
    );

    segaabb_back #(.COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(q_empty), .o_pop(b_pop),
        .i_data(q_data), .i_out_count(o_count), .o_valid(b_valid), .o_data(b_data)
    );

    segaabb_fifo #(.DW(RW), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(b_valid), .i_data(b_data),
        .i_pop(pop), .o_data(res), .o_empty(empty), .o_count(o_count)
    );

    assign o_hit        = res.hit;
    assign o_hit_x      = res.p[0];
    assign o_hit_y      = res.p[1];
    assign o_hit_z      = res.p[2];
    assign o_entry_axis = res.axis;
    assign o_entry_time = res.t;

endmodule
`default_nettype wire

// ----- tb/sv/segaabb_checker.sv -----
// ----------------------------------------------------------------------------
// segaabb_checker
// Watches both queue interfaces of the segment/box entry test. Computes the
// expected entry result for every accepted transaction, holds the results in
// order, and compares every popped result field by field.
// ----------------------------------------------------------------------------
module segaabb_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic [11:0][31:0]  i_seg_box,
    input  wire logic               i_empty,
    input  wire logic               i_pop,
    input  wire logic               i_hit,
    input  wire logic signed [31:0] i_hit_x,
    input  wire logic signed [31:0] i_hit_y,
    input  wire logic signed [31:0] i_hit_z,
    input  wire logic [1:0]         i_entry_axis,
    input  wire logic [16:0]        i_entry_time,
    output int                      o_fail_cnt,
    output int                      o_pending
);

    import segaabb_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [2:0][31:0]  pnt;
        logic [1:0]        axis;
        logic [16:0]       tm;
    } t_entry;

    t_entry entry_q[$];
    int     fail_cnt = 0;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = entry_q.size();

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // floor(num * 2^16 / den), saturating at 1.0
    function automatic longint plane_time(longint num, longint den);
        if (num >= den)
            return 64'd65536;
        return (num <<< 16) / den;
    endfunction

    function automatic t_entry predict_entry(logic [11:0][31:0] v);
        t_entry  r;
        longint  s[3], d[3], lo[3], hi[3], tc[3], p[3];
        longint  gap, m, off;
        bit      in_box;
        int      best;
        r      = '0;
        in_box = 1'b1;
        for (int a = 0; a < 3; a++) begin
            s[a]  = longint'($signed(v[a]));
            d[a]  = longint'($signed(v[3 + a]));
            lo[a] = longint'($signed(v[6 + 2 * a]));
            hi[a] = longint'($signed(v[7 + 2 * a]));
        end
        for (int a = 0; a < 3; a++) begin
            if (s[a] < lo[a]) begin
                gap = lo[a] - s[a];
                if (gap > d[a])
                    return r;
                tc[a]  = plane_time(abs64(gap), abs64(d[a]));
                in_box = 1'b0;
            end else if (s[a] > hi[a]) begin
                gap = hi[a] - s[a];
                if (gap < d[a])
                    return r;
                tc[a]  = plane_time(abs64(gap), abs64(d[a]));
                in_box = 1'b0;
            end else begin
                tc[a] = -1;
            end
        end
        if (in_box)
            return r;
        best = 0;
        if (tc[1] > tc[best])
            best = 1;
        if (tc[2] > tc[best])
            best = 2;
        for (int a = 0; a < 3; a++) begin
            m    = abs64(d[a]);
            off  = (m >>> 16) * tc[best] + (((m & 64'hffff) * tc[best]) >>> 16);
            p[a] = (d[a] < 0) ? s[a] - off : s[a] + off;
        end
        for (int k = 0; k < 3; k++)
            if (k != best && (p[k] < lo[k] || p[k] > hi[k]))
                return r;
        r.hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (p[a] > 64'sd2147483647)
                r.pnt[a] = 32'h7fffffff;
            else if (p[a] < -64'sd2147483648)
                r.pnt[a] = 32'h80000000;
            else
                r.pnt[a] = p[a][31:0];
        end
        r.axis = (best == 0) ? AXIS_X : (best == 1) ? AXIS_Y : AXIS_Z;
        r.tm   = tc[best][16:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_entry want, got;
        if (i_rst_n && i_push && !i_full)
            entry_q.push_back(predict_entry(i_seg_box));
        if (i_rst_n && i_pop && !i_empty) begin
            got.hit  = i_hit;
            got.pnt  = {i_hit_z, i_hit_y, i_hit_x};
            got.axis = i_entry_axis;
            got.tm   = i_entry_time;
            if (entry_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result transaction: %p", got);
            end else begin
                want = entry_q.pop_front();
                if (got !== want) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"mismatch: hit %0b/%0b x %h/%h y %h/%h z %h/%h",
                                  " axis %0d/%0d t %0d/%0d"},
                                 want.hit, got.hit, want.pnt[0], got.pnt[0],
                                 want.pnt[1], got.pnt[1], want.pnt[2], got.pnt[2],
                                 want.axis, got.axis, want.tm, got.tm);
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_segment_aabb_intersect_top.sv -----
// ----------------------------------------------------------------------------
// tb_segment_aabb_intersect_top
// Drives directed and random segment/box transactions with random idle bursts
// and one long result hold-off; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_segment_aabb_intersect_top;
    import segaabb_pkg::*;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] CMAX = 32'h7fff_ffff;
    localparam logic [31:0] CMIN = 32'h8000_0000;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              push      = 1'b0;
    logic              pop       = 1'b0;
    logic [11:0][31:0] seg_box   = '0;
    bit                calm      = 1'b0;
    logic              full, empty, o_hit;
    logic signed [31:0] o_hit_x, o_hit_y, o_hit_z;
    logic [1:0]        o_entry_axis;
    logic [16:0]       o_entry_time;
    int                fail_cnt, pending;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    segment_aabb_intersect_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_start_x(seg_box[0]), .i_start_y(seg_box[1]), .i_start_z(seg_box[2]),
        .i_dir_x(seg_box[3]), .i_dir_y(seg_box[4]), .i_dir_z(seg_box[5]),
        .i_box_min_x(seg_box[6]), .i_box_max_x(seg_box[7]),
        .i_box_min_y(seg_box[8]), .i_box_max_y(seg_box[9]),
        .i_box_min_z(seg_box[10]), .i_box_max_z(seg_box[11]),
        .empty(empty), .pop(pop), .o_hit(o_hit), .o_hit_x(o_hit_x),
        .o_hit_y(o_hit_y), .o_hit_z(o_hit_z), .o_entry_axis(o_entry_axis),
        .o_entry_time(o_entry_time)
    );

    segaabb_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_seg_box(seg_box), .i_empty(empty), .i_pop(pop), .i_hit(o_hit),
        .i_hit_x(o_hit_x), .i_hit_y(o_hit_y), .i_hit_z(o_hit_z),
        .i_entry_axis(o_entry_axis), .i_entry_time(o_entry_time),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    function automatic logic [11:0][31:0] seg(
        logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
        logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
        logic [31:0] lx, logic [31:0] hx, logic [31:0] ly,
        logic [31:0] hy, logic [31:0] lz, logic [31:0] hz);
        return {hz, lz, hy, ly, hx, lx, dz, dy, dx, sz, sy, sx};
    endfunction

    // one aimed segment: start near a random box, end near or past a point in it
    function automatic logic [11:0][31:0] aimed_seg();
        logic [11:0][31:0] v;
        int sh, c, h, tgt, st;
        sh = $urandom_range(0, 10);
        for (int a = 0; a < 3; a++) begin
            c   = int'($urandom_range(0, 32'h3fff_ffff)) - 32'h2000_0000;
            h   = int'($urandom_range(0, 32'h00ff_ffff) >> sh);
            tgt = c + int'($urandom_range(0, 2 * h)) - h;
            st  = c + int'($urandom_range(0, 32'h03ff_ffff) >> sh) - (32'h01ff_ffff >> sh);
            v[a]         = st;
            v[3 + a]     = ($urandom_range(0, 3) == 0) ? (tgt - st) * 2 : tgt - st;
            v[6 + 2 * a] = c - h;
            v[7 + 2 * a] = c + h;
        end
        return v;
    endfunction

    task automatic send_seg(logic [11:0][31:0] v);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        seg_box <= v;
        push    <= 1'b1;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    // result side: random pop bursts, one long hold-off to fill the block
    initial begin
        int cyc;
        cyc = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 700) begin
                pop <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            pop <= 1'b1;
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [11:0][31:0] v;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start inside the box
        send_seg(seg(0, 0, 0, ONE, ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        // enter on x from below and from above
        send_seg(seg(-2 * ONE, 0, 0, 4 * ONE, 0, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        send_seg(seg(2 * ONE, 0, 0, -4 * ONE, 0, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        // enter on y from below, on z from above
        send_seg(seg(0, -3 * ONE, 0, 0, 5 * ONE, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        send_seg(seg(0, 0, 3 * ONE, 0, 0, -7 * ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        // ties: x with y, then all three
        send_seg(seg(-2 * ONE, -2 * ONE, 0, 4 * ONE, 4 * ONE, 0,
                     -ONE, ONE, -ONE, ONE, -ONE, ONE));
        send_seg(seg(-2 * ONE, -2 * ONE, -2 * ONE, 4 * ONE, 4 * ONE, 4 * ONE,
                     -ONE, ONE, -ONE, ONE, -ONE, ONE));
        // zero direction on an outside axis
        send_seg(seg(-2 * ONE, 0, 0, 0, ONE, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        // plane out of reach, then reached exactly at the end
        send_seg(seg(-3 * ONE, 0, 0, ONE, 0, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        send_seg(seg(-2 * ONE, 0, 0, ONE, 0, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        // inverted box
        send_seg(seg(0, 0, 0, ONE, 0, 0, ONE, -ONE, -ONE, ONE, -ONE, ONE));
        // full-range extremes
        send_seg(seg(CMIN, 0, 0, CMAX, 0, 0, 0, CMAX, CMIN, CMAX, CMIN, CMAX));
        send_seg(seg(CMIN, 0, 0, CMAX, 0, 0, -1, CMAX, CMIN, CMAX, CMIN, CMAX));
        send_seg(seg(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
        send_seg(seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_seg(seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_seg(seg(CMAX, 0, 0, CMIN, 0, 0, CMIN, -1, CMIN, CMAX, CMIN, CMAX));
        // other coordinate outside after entry, then exactly on the bound
        send_seg(seg(-2 * ONE, 5 * ONE, 0, 4 * ONE, 0, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        send_seg(seg(-2 * ONE, ONE, 0, 4 * ONE, 0, 0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
        // odd fractions for the divider
        send_seg(seg(-ONE - 1, 7, 0, 3 * ONE + 5, 3, 0, -1, ONE, 0, ONE, -ONE, ONE));

        for (n = 0; n < 1300; n++) begin
            if (n == 1100)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: begin
                    for (int k = 0; k < 12; k++)
                        v[k] = $urandom;
                end
                2: begin
                    v = aimed_seg();
                    v[$urandom_range(0, 11)] = $urandom;
                end
                default: v = aimed_seg();
            endcase
            send_seg(v);
        end
        push <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
